FILE: rtl/sgad_pkg.sv
// ----------------------------------------------------------------------------
// sgad_pkg
// types and constants shared by the stick gesture arm detector
// ----------------------------------------------------------------------------
package sgad_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int STICK_W = 10;

  // arm modes
  localparam logic [1:0] MODE_DISARMED = 2'd0;
  localparam logic [1:0] MODE_ARMING1  = 2'd1;
  localparam logic [1:0] MODE_ARMING2  = 2'd2;
  localparam logic [1:0] MODE_ARMED    = 2'd3;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_GESTURE_THR  = 3'd0;
  localparam logic [2:0] REG_START_THR    = 3'd1;
  localparam logic [2:0] REG_THROTTLE_TOL = 3'd2;
  localparam logic [2:0] REG_STEP2_TO     = 3'd3;
  localparam logic [2:0] REG_STEP3_TO     = 3'd4;
  localparam logic [2:0] REG_STEP4_TO     = 3'd5;

  typedef struct packed {
    logic [8:0] gesture_threshold;
    logic [8:0] start_threshold;
    logic [9:0] throttle_tolerance;
    logic [7:0] step2_timeout;
    logic [7:0] step3_timeout;
    logic [7:0] step4_timeout;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    gesture_threshold:  9'd450,
    start_threshold:    9'd20,
    throttle_tolerance: 10'd5,
    step2_timeout:      8'd6,
    step3_timeout:      8'd10,
    step4_timeout:      8'd7
  };

  typedef struct packed {
    logic [9:0]        throttle;
    logic signed [9:0] yaw;
    logic signed [9:0] pitch;
    logic signed [9:0] roll;
    logic              switch_low;
  } item_t;

  typedef struct packed {
    logic [31:0] tick_count;
    logic [31:0] step_start;
    logic        idle_seen;
    logic        yaw_seen;
    logic        roll_seen;
    logic [1:0]  arm_mode;
  } state_t;

endpackage

FILE: rtl/sgad_step.sv
// ----------------------------------------------------------------------------
// sgad_step
// next-state logic for one tick: the four gesture step checks in order
// ----------------------------------------------------------------------------
module sgad_step (
  input  sgad_pkg::cfg_t   cfg,
  input  sgad_pkg::item_t  item,
  input  sgad_pkg::state_t cur,
  output sgad_pkg::state_t nxt
);

  logic               arming;
  logic               idle;
  logic               thr_bad;
  logic signed [10:0] yaw_x;
  logic signed [10:0] roll_x;
  logic signed [10:0] dir_yaw;
  logic signed [10:0] dir_roll;
  logic signed [10:0] g_s;
  logic signed [10:0] s_s;
  logic [31:0]        elapsed;
  logic               late2;
  logic               late3;
  logic               late4;

  assign arming   = (cur.arm_mode != sgad_pkg::MODE_ARMED);
  assign idle     = (item.throttle == '0) && (item.yaw == '0) &&
                    (item.pitch == '0) && (item.roll == '0);
  assign thr_bad  = (item.throttle > cfg.throttle_tolerance);
  assign yaw_x    = 11'(item.yaw);
  assign roll_x   = 11'(item.roll);
  // disarming mirrors the yaw and roll signs
  assign dir_yaw  = arming ? yaw_x : -yaw_x;
  assign dir_roll = arming ? roll_x : -roll_x;
  assign g_s      = signed'({2'b00, cfg.gesture_threshold});
  assign s_s      = signed'({2'b00, cfg.start_threshold});
  // elapsed ticks since the stamp held at the start of this tick
  assign elapsed  = cur.tick_count - cur.step_start;
  assign late2    = (elapsed > {24'd0, cfg.step2_timeout});
  assign late3    = (elapsed > {24'd0, cfg.step3_timeout});
  assign late4    = (elapsed > {24'd0, cfg.step4_timeout});

  always_comb begin
    logic fresh;
    fresh = 1'b0;
    nxt   = cur;

    // step one: idle sticks
    if (!nxt.idle_seen) begin
      nxt.yaw_seen  = 1'b0;
      nxt.roll_seen = 1'b0;
      if (arming) begin
        nxt.arm_mode = sgad_pkg::MODE_DISARMED;
      end
      if (idle && (item.switch_low || !arming)) begin
        nxt.idle_seen = 1'b1;
      end
    end

    // step two: yaw; a restamp this tick means zero elapsed
    if (nxt.idle_seen && !nxt.yaw_seen) begin
      if (dir_yaw < s_s) begin
        nxt.step_start = cur.tick_count;
        fresh          = 1'b1;
      end
      if (thr_bad || (item.pitch != '0) || (item.roll != '0) || (!fresh && late2)) begin
        nxt.idle_seen = 1'b0;
      end
      if (dir_yaw > g_s) begin
        nxt.idle_seen  = 1'b1;
        nxt.yaw_seen   = 1'b1;
        if (arming) begin
          nxt.arm_mode = sgad_pkg::MODE_ARMING1;
        end
        nxt.step_start = cur.tick_count;
        fresh          = 1'b1;
      end
    end

    // step three: roll
    if (nxt.idle_seen && nxt.yaw_seen && !nxt.roll_seen) begin
      if ((dir_yaw < g_s) || thr_bad || (item.pitch != '0) || (!fresh && late3)) begin
        nxt.idle_seen = 1'b0;
      end
      if (dir_roll < -g_s) begin
        nxt.idle_seen  = 1'b1;
        nxt.yaw_seen   = 1'b1;
        nxt.roll_seen  = 1'b1;
        if (arming) begin
          nxt.arm_mode = sgad_pkg::MODE_ARMING2;
        end
        nxt.step_start = cur.tick_count;
        fresh          = 1'b1;
      end
    end

    // step four: back to idle
    if (nxt.roll_seen) begin
      if (!fresh && late4) begin
        nxt.idle_seen = 1'b0;
      end
      if (idle) begin
        nxt.idle_seen = 1'b0;
        nxt.arm_mode  = arming ? sgad_pkg::MODE_ARMED : sgad_pkg::MODE_DISARMED;
      end
    end

    nxt.tick_count = cur.tick_count + 32'd1;
  end

endmodule

FILE: rtl/stick_gesture_arm_detector_top.sv
// ----------------------------------------------------------------------------
// stick_gesture_arm_detector_top
// recognizes arm and disarm stick gestures, one tick item in, one arm state out
// ----------------------------------------------------------------------------
//
//   channel   handshake              payload
//   -------   --------------------   ---------------------------------------
//   in        in_valid / in_stall    throttle, yaw, pitch, roll, switch_low
//   out       out_valid / out_stall  arm_state
//   config    apb psel/penable/...   six registers at 4*index
//
// one transfer per clock in steady state while out is not stalled: an item is
// held in the input register, then the step logic updates the gesture state
// and the result register in the same edge, and the result register drives out.
// the single feedback loop through the gesture state sets that rate.
// rst (synchronous) clears the gesture state, tick count and both valids and
// loads the register defaults. a stall on out holds the result; in stalls
// only while both the input and result registers are occupied.
// ----------------------------------------------------------------------------
module stick_gesture_arm_detector_top (
  input  logic                        clk,
  input  logic                        rst,
  // tick input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [9:0]                  throttle,
  input  logic signed [9:0]           yaw,
  input  logic signed [9:0]           pitch,
  input  logic signed [9:0]           roll,
  input  logic                        switch_low,
  // arm state output
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  arm_state,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sgad_pkg::ADDR_W-1:0] paddr,
  input  logic [sgad_pkg::DATA_W-1:0] pwdata,
  output logic [sgad_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  sgad_pkg::cfg_t   cfg_q;
  sgad_pkg::item_t  item_q;
  sgad_pkg::state_t state_q;
  sgad_pkg::state_t state_next;
  logic             item_valid;
  logic             advance;
  logic             cfg_write;
  logic [2:0]       reg_index;

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q <= sgad_pkg::CFG_RESET;
    end else if (cfg_write) begin
      case (reg_index)
        sgad_pkg::REG_GESTURE_THR:  cfg_q.gesture_threshold  <= pwdata[8:0];
        sgad_pkg::REG_START_THR:    cfg_q.start_threshold    <= pwdata[8:0];
        sgad_pkg::REG_THROTTLE_TOL: cfg_q.throttle_tolerance <= pwdata[9:0];
        sgad_pkg::REG_STEP2_TO:     cfg_q.step2_timeout      <= pwdata[7:0];
        sgad_pkg::REG_STEP3_TO:     cfg_q.step3_timeout      <= pwdata[7:0];
        sgad_pkg::REG_STEP4_TO:     cfg_q.step4_timeout      <= pwdata[7:0];
        default: ; // addresses past the last register are ignored
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    case (reg_index)
      sgad_pkg::REG_GESTURE_THR:  prdata = {23'd0, cfg_q.gesture_threshold};
      sgad_pkg::REG_START_THR:    prdata = {23'd0, cfg_q.start_threshold};
      sgad_pkg::REG_THROTTLE_TOL: prdata = {22'd0, cfg_q.throttle_tolerance};
      sgad_pkg::REG_STEP2_TO:     prdata = {24'd0, cfg_q.step2_timeout};
      sgad_pkg::REG_STEP3_TO:     prdata = {24'd0, cfg_q.step3_timeout};
      sgad_pkg::REG_STEP4_TO:     prdata = {24'd0, cfg_q.step4_timeout};
      default:                    prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  // the held item moves on whenever the result register is free or draining
  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && out_valid && out_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_q.throttle   <= throttle;
      item_q.yaw        <= yaw;
      item_q.pitch      <= pitch;
      item_q.roll       <= roll;
      item_q.switch_low <= switch_low;
    end
  end

  // ---------------- gesture step logic ----------------
  sgad_step u_step (
    .cfg  (cfg_q),
    .item (item_q),
    .cur  (state_q),
    .nxt  (state_next)
  );

  // gesture state and result register update together
  always_ff @(posedge clk) begin
    if (rst) begin
      state_q   <= '0;
      out_valid <= 1'b0;
      arm_state <= sgad_pkg::MODE_DISARMED;
    end else if (advance) begin
      state_q   <= state_next;
      out_valid <= 1'b1;
      arm_state <= state_next.arm_mode;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: rtl/sgad_checker.sv
// ----------------------------------------------------------------------------
// sgad_checker
// port-level checks on the arm detector, bound to the top level
// ----------------------------------------------------------------------------
module sgad_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] arm_state
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(arm_state))
    else $error("stalled result changed");

  // reset empties the result register
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // input only backs up behind a full, stalled result register
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // from armed the only way out is disarmed
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && ($past(arm_state) == sgad_pkg::MODE_ARMED) |->
      (arm_state == sgad_pkg::MODE_ARMED) || (arm_state == sgad_pkg::MODE_DISARMED))
    else $error("armed left to an arming stage");

  // disarmed cannot jump straight to armed
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && ($past(arm_state) == sgad_pkg::MODE_DISARMED) |->
      (arm_state != sgad_pkg::MODE_ARMED))
    else $error("disarmed jumped to armed");

endmodule

bind stick_gesture_arm_detector_top sgad_checker u_checker (.*);

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the stick gesture arm detector
//
// an initial block fills a queue of stick ticks: a short directed run, then
// mostly well-formed arm and disarm gestures with random content plus noise.
// a clocked driver offers the ticks on the input channel and runs a local
// gesture predictor on each transfer. a clocked monitor compares every arm
// state on the output channel with the oldest prediction. the register set
// is rewritten between phases, and each phase uses one of four mixes of sender
// gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // register slots above the last real one, writes there must change nothing
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  localparam int NUM_PHASES     = 8;
  localparam int PHASE_TICKS    = 120;
  localparam int QUIET_LIMIT    = 2000;
  localparam int HOLD_OFF_LEN   = 80;
  localparam int SETTLE_CYCLES  = 4;
  localparam int MAX_REPORTED   = 10;
  localparam int MAX_WANDER     = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // input channel, known from time zero
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [9:0]        throttle   = '0;
  logic signed [9:0] yaw        = '0;
  logic signed [9:0] pitch      = '0;
  logic signed [9:0] roll       = '0;
  logic              switch_low = 1'b0;

  // output channel
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] arm_state;

  // configuration port
  logic                        psel    = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite  = 1'b0;
  logic [sgad_pkg::ADDR_W-1:0] paddr   = '0;
  logic [sgad_pkg::DATA_W-1:0] pwdata  = '0;
  logic [sgad_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  stick_gesture_arm_detector_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .throttle  (throttle),
    .yaw       (yaw),
    .pitch     (pitch),
    .roll      (roll),
    .switch_low(switch_low),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .arm_state (arm_state),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ticks waiting to be offered, and arm states waiting to come out
  sgad_pkg::item_t ticks_to_send[$];
  logic [1:0]      predicted_arm_states[$];
  sgad_pkg::item_t on_wire;

  // traffic shaping knobs, set per phase
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int noise_pct       = 0;
  int phase_ticks     = 0;

  int mismatches    = 0;
  int results_seen  = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  // predictor: register copy and gesture state, reset values at start
  sgad_pkg::cfg_t cfg_now = sgad_pkg::CFG_RESET;
  logic [31:0]    tick_q  = '0;
  logic [31:0]    stamp_q = '0;
  logic           idle_ok = 1'b0;
  logic           yaw_ok  = 1'b0;
  logic           roll_ok = 1'b0;
  logic [1:0]     mode_q  = sgad_pkg::MODE_DISARMED;

  // advance the gesture state by one tick and give the resulting arm state
  function automatic logic [1:0] advance_gesture(sgad_pkg::item_t t);
    logic arming, idle, thr_bad;
    int   y, p, r, g, s, dy, dr;
    arming  = (mode_q != sgad_pkg::MODE_ARMED);
    y       = $signed(t.yaw);
    p       = $signed(t.pitch);
    r       = $signed(t.roll);
    g       = int'(cfg_now.gesture_threshold);
    s       = int'(cfg_now.start_threshold);
    // disarming mirrors the yaw and roll directions
    dy      = arming ? y : -y;
    dr      = arming ? r : -r;
    idle    = (t.throttle == 0) && (y == 0) && (p == 0) && (r == 0);
    thr_bad = (t.throttle > cfg_now.throttle_tolerance);

    // step one: idle sticks, switch low only matters when arming
    if (!idle_ok) begin
      yaw_ok  = 1'b0;
      roll_ok = 1'b0;
      if (arming) mode_q = sgad_pkg::MODE_DISARMED;
      if (idle && (t.switch_low || !arming)) idle_ok = 1'b1;
    end

    // step two: yaw past the threshold
    if (idle_ok && !yaw_ok) begin
      if (dy < s) stamp_q = tick_q;
      if (thr_bad || p != 0 || r != 0 ||
          (tick_q - stamp_q) > {24'd0, cfg_now.step2_timeout}) idle_ok = 1'b0;
      if (dy > g) begin
        idle_ok = 1'b1;
        yaw_ok  = 1'b1;
        if (arming) mode_q = sgad_pkg::MODE_ARMING1;
        stamp_q = tick_q;
      end
    end

    // step three: roll past the threshold with yaw still held
    if (idle_ok && yaw_ok && !roll_ok) begin
      if (dy < g || thr_bad || p != 0 ||
          (tick_q - stamp_q) > {24'd0, cfg_now.step3_timeout}) idle_ok = 1'b0;
      if (dr < -g) begin
        idle_ok = 1'b1;
        yaw_ok  = 1'b1;
        roll_ok = 1'b1;
        if (arming) mode_q = sgad_pkg::MODE_ARMING2;
        stamp_q = tick_q;
      end
    end

    // step four: back to idle, a timeout only drops idle_ok here
    if (roll_ok) begin
      if ((tick_q - stamp_q) > {24'd0, cfg_now.step4_timeout}) idle_ok = 1'b0;
      if (idle) begin
        idle_ok = 1'b0;
        mode_q  = arming ? sgad_pkg::MODE_ARMED : sgad_pkg::MODE_DISARMED;
      end
    end

    tick_q = tick_q + 32'd1;
    return mode_q;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued ticks, predicts on every input transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_arm_states.push_back(advance_gesture(on_wire));
      end
      // payload only moves once the current one is gone or none is offered
      if (!in_valid || !in_stall) begin
        if (ticks_to_send.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          on_wire    = ticks_to_send.pop_front();
          throttle   <= on_wire.throttle;
          yaw        <= on_wire.yaw;
          pitch      <= on_wire.pitch;
          roll       <= on_wire.roll;
          switch_low <= on_wire.switch_low;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks arm states in order and drives the receiver stall
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic       took;
    logic [1:0] want;
    took = !rst && out_valid && !out_stall;
    if (took) begin
      if (predicted_arm_states.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < MAX_REPORTED)
          $display("tb: arm state %0d with no tick pending", arm_state);
      end else begin
        want = predicted_arm_states.pop_front();
        if (arm_state !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < MAX_REPORTED)
            $display("tb: arm state mismatch at result %0d: expected %0d, got %0d",
                     results_seen, want, arm_state);
        end
      end
      results_seen <= results_seen + 1;
    end

    // a long hold-off twice in the run, so the block backs up into its input
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (took && (results_seen == 150 || results_seen == 600)) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_OFF_LEN;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // watchdog: too long with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int pick(int lo, int hi);
    if (lo >= hi) return hi;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic sgad_pkg::item_t random_tick();
    sgad_pkg::item_t t;
    t.throttle   = 10'($urandom_range(0, 1023));
    t.yaw        = 10'($urandom_range(0, 1023));
    t.pitch      = 10'($urandom_range(0, 1023));
    t.roll       = 10'($urandom_range(0, 1023));
    t.switch_low = 1'($urandom_range(0, 1));
    return t;
  endfunction

  // queue one tick, now and then swapped for a fully random one
  task automatic queue_tick(int thr, int y, int p, int r, bit sw);
    sgad_pkg::item_t t;
    if ($urandom_range(0, 99) < noise_pct) begin
      t = random_tick();
    end else begin
      t.throttle   = thr[9:0];
      t.yaw        = y[9:0];
      t.pitch      = p[9:0];
      t.roll       = r[9:0];
      t.switch_low = sw;
    end
    ticks_to_send.push_back(t);
    phase_ticks++;
  endtask

  // dwell length for a step: usually short, sometimes around the timeout
  function automatic int dwell(logic [7:0] limit);
    int n;
    if ($urandom_range(0, 3) == 0) n = $urandom_range(0, int'(limit) + 2);
    else n = $urandom_range(0, 3);
    return (n > MAX_WANDER) ? MAX_WANDER : n;
  endfunction

  // one gesture: dir +1 arms, -1 disarms
  task automatic queue_gesture(int dir);
    int g, s, tol, yaw_top, roll_top;
    bit sw;
    g        = int'(cfg_now.gesture_threshold);
    s        = int'(cfg_now.start_threshold);
    tol      = int'(cfg_now.throttle_tolerance);
    // negative side reaches one further
    yaw_top  = (dir > 0) ? 511 : 512;
    roll_top = (dir > 0) ? 512 : 511;
    sw       = ($urandom_range(0, 7) != 0);

    // idle sticks
    repeat ($urandom_range(1, 3)) queue_tick(0, 0, 0, 0, sw);
    // yaw under the start level, drifting, then past the threshold
    repeat ($urandom_range(0, 3))
      queue_tick(pick(0, tol), dir * pick(0, s - 1), 0, 0, 1'($urandom_range(0, 1)));
    repeat (dwell(cfg_now.step2_timeout))
      queue_tick(pick(0, tol), dir * pick(s, g), 0, 0, 1'($urandom_range(0, 1)));
    queue_tick(pick(0, tol), dir * pick(g + 1, yaw_top), 0, 0, 1'($urandom_range(0, 1)));
    // roll building up with yaw held, then past the threshold
    repeat (dwell(cfg_now.step3_timeout))
      queue_tick(pick(0, tol), dir * pick(g, yaw_top), 0, -dir * pick(0, g),
                 1'($urandom_range(0, 1)));
    queue_tick(pick(0, tol), dir * pick(g, yaw_top), 0, -dir * pick(g + 1, roll_top),
               1'($urandom_range(0, 1)));
    // sticks wander back, then idle
    repeat (dwell(cfg_now.step4_timeout))
      queue_tick(pick(1, 1023), pick(0, 40) - 20, 0, pick(0, 40) - 20,
                 1'($urandom_range(0, 1)));
    queue_tick(0, 0, 0, 0, 1'($urandom_range(0, 1)));
  endtask

  // register write: setup then access, written when pready is seen high
  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      sgad_pkg::REG_GESTURE_THR:  cfg_now.gesture_threshold  = value[8:0];
      sgad_pkg::REG_START_THR:    cfg_now.start_threshold    = value[8:0];
      sgad_pkg::REG_THROTTLE_TOL: cfg_now.throttle_tolerance = value[9:0];
      sgad_pkg::REG_STEP2_TO:     cfg_now.step2_timeout      = value[7:0];
      sgad_pkg::REG_STEP3_TO:     cfg_now.step3_timeout      = value[7:0];
      sgad_pkg::REG_STEP4_TO:     cfg_now.step4_timeout      = value[7:0];
      default: ;
    endcase
  endtask

  // sender pause: everything offered and every arm state back, then settle
  task automatic wait_drained();
    while (ticks_to_send.size() != 0 || in_valid || predicted_arm_states.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // sequence: reset, directed ticks, then phases of config and random gestures
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] fill;
    bit          disarm_next;
    disarm_next = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, at reset register values
    queue_tick(1023, -512, -512, -512, 1'b1);   // field extremes
    queue_tick(0, 511, 511, 511, 1'b0);
    queue_tick(0, 0, 0, 0, 1'b1);               // idle with switch low
    queue_tick(5, 460, 0, -460, 1'b0);          // yaw and roll steps in one tick
    queue_tick(0, 0, 0, 0, 1'b0);               // back to idle: armed
    queue_tick(0, 0, 0, 0, 1'b0);               // disarm idle, switch ignored
    queue_tick(0, -500, 0, 500, 1'b1);          // mirrored yaw and roll together
    repeat (9) queue_tick(1, 0, 0, 0, 1'b0);    // step four runs out of time
    queue_tick(0, 0, 0, 0, 1'b1);               // idle check still applies
    queue_tick(0, 0, 0, 0, 1'b1);
    queue_tick(6, 30, 0, 0, 1'b1);              // throttle just over tolerance
    queue_tick(0, 0, 0, 0, 1'b1);
    queue_tick(0, 460, 0, 0, 1'b1);
    queue_tick(0, 460, 0, -450, 1'b1);          // roll exactly at threshold
    queue_tick(0, 460, 0, -451, 1'b1);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) begin
        wait_drained();
        for (int i = 0; i < 6; i++) begin
          case (ph)
            1:       fill = 32'd0;             // all thresholds and timeouts zero
            2:       fill = 32'hFFFF_FFFF;     // everything at its top value
            default: fill = $urandom;          // upper bits must be ignored
          endcase
          reg_write(3'(i), fill);
        end
        reg_write(REG_SPARE_LO, $urandom);
        reg_write(REG_SPARE_HI, $urandom);
        @(negedge clk);
      end

      // gaps and stalls: none, sender idle, receiver stall, both
      case (ph % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin sender_idle_pct = 13; recv_stall_pct = 13; end
      endcase

      noise_pct   = 4;
      phase_ticks = 0;
      while (phase_ticks < PHASE_TICKS) begin
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 5)) ticks_to_send.push_back(random_tick());
          phase_ticks += 3;
        end else begin
          // mostly alternate arm and disarm, sometimes try the wrong way
          if ($urandom_range(0, 4) == 0) disarm_next = 1'($urandom_range(0, 1));
          queue_gesture(disarm_next ? -1 : 1);
          disarm_next = !disarm_next;
        end
      end
      noise_pct = 0;
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
